>>> rtl/foc_space_vector_modulator_defines.svh
// assertion macros for the space vector modulator
`ifndef FOC_SPACE_VECTOR_MODULATOR_DEFINES_SVH
`define FOC_SPACE_VECTOR_MODULATOR_DEFINES_SVH
// property that must hold whenever reset is low
`define SVM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked during and after reset
`define SVM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> rtl/svm_pkg.sv
// shared types, constants and functions for the space vector modulator
package svm_pkg;
  localparam int PWM_PERIOD = 4095;
  localparam int ANGLE_BITS = 16;
  localparam int SQRT3_Q16 = 113512;
  localparam int DIV_STEPS = 17;
  localparam logic [1:0] REG_SUPPLY = 2'd0;
  localparam logic [1:0] REG_VD = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;

  typedef struct packed {
    logic signed [15:0] q_axis_voltage;
    logic [15:0] rotor_angle;
  } svm_in_t;

  typedef struct packed {
    logic [11:0] compare_a;
    logic [11:0] compare_b;
    logic [11:0] compare_c;
    logic [2:0] sector;
  } svm_out_t;

  // one division lane: remainder, quotient and saturation flags
  typedef struct packed {
    logic [63:0] rem;
    logic [17:0] quo;
    logic sat_hi;
    logic sat_lo;
  } div_lane_t;

  function automatic logic [2:0] sector_of_code(input logic [2:0] code);
    logic [2:0] s;
    unique case (code)
      3'd0: s = 3'd1;
      3'd1: s = 3'd2;
      3'd2: s = 3'd6;
      3'd3: s = 3'd1;
      3'd4: s = 3'd4;
      3'd5: s = 3'd3;
      3'd6: s = 3'd5;
      default: s = 3'd1;
    endcase
    return s;
  endfunction

  function automatic logic [11:0] to_compare(input logic [17:0] duty);
    logic [16:0] d;
    logic [29:0] c;
    d = (duty > 18'd65536) ? 17'd65536 : duty[16:0];
    c = (30'(d) * 30'(PWM_PERIOD) + 30'd32768) >> 16;
    if (c > 30'(PWM_PERIOD)) c = 30'(PWM_PERIOD);
    return c[11:0];
  endfunction
endpackage

>>> rtl/svm_sincos.sv
// pipelined quarter-wave sine evaluation, three register stages
module svm_sincos (
  input  logic clk,
  input  logic [15:0] phase,
  output logic signed [17:0] sin_val
);
  import svm_pkg::*;
  localparam logic [31:0] SA = 32'd102944;
  localparam logic [31:0] SB = 32'd42048;
  localparam logic [31:0] SC = 32'd4640;

  logic [16:0] z0, z1, z2r;
  logic [16:0] zsq1;
  logic [1:0] q0, q1, q2;
  logic [31:0] t2;
  logic [33:0] zz;
  logic [16:0] zsq;
  logic [49:0] tc;
  logic [49:0] tb;
  logic [49:0] tz;
  logic [17:0] r;

  // fold phase into a quadrant
  always_comb begin
    z0 = phase[14] ? (17'd65536 - {1'b0, phase[13:0], 2'b0}) : {1'b0, phase[13:0], 2'b0};
    zz = 34'(z0) * 34'(z0);
    zsq = zz[32:16];
  end

  always_ff @(posedge clk) begin
    z1 <= z0;
    zsq1 <= zsq;
    q1 <= phase[15:14];
  end

  // inner polynomial terms
  always_comb begin
    tc = (50'(SC) * 50'(zsq1)) >> 16;
    tb = ((50'(SB) - tc) * 50'(zsq1)) >> 16;
  end

  always_ff @(posedge clk) begin
    t2 <= SA - tb[31:0];
    z2r <= z1;
    q2 <= q1;
  end

  // final product and rounding
  always_comb begin
    tz = (50'(t2) * 50'(z2r) + 50'd65536) >> 17;
    r = tz[17:0];
    q0 = q2;
  end

  always_ff @(posedge clk) begin
    sin_val <= q0[1] ? -$signed(r) : $signed(r);
  end
endmodule

>>> rtl/svm_div_lane.sv
// one restoring division step for a clamped rounded ratio
module svm_div_lane (
  input  logic clk,
  input  logic [63:0] den,
  input  svm_pkg::div_lane_t lane_in,
  output svm_pkg::div_lane_t lane_out
);
  import svm_pkg::*;
  logic [64:0] r2;
  div_lane_t lane_out_next;
  always_comb begin
    r2 = {lane_in.rem, 1'b0};
    lane_out_next = lane_in;
    lane_out_next.quo = {lane_in.quo[16:0], 1'b0};
    if (r2 >= 65'(den)) begin
      lane_out_next.rem = 64'(r2 - 65'(den));
      lane_out_next.quo[0] = 1'b1;
    end else begin
      lane_out_next.rem = r2[63:0];
    end
  end
  always_ff @(posedge clk) lane_out <= lane_out_next;
endmodule

>>> rtl/foc_space_vector_modulator.sv
// top level: inverse park, sector, timing ratios and compare values
// The modulator takes one item per clock and passes each item through 3 sine
// stages, 4 transform stages, 17 divider stages and 2 output stages, raising
// done with the result; busy stays low. Most of the depth is the pipelined
// ratio divider, one quotient bit per stage across three parallel lanes.
// Results come with done high for one cycle and cannot be held off.
// Configuration must be written while no item is in flight.
module foc_space_vector_modulator (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  svm_pkg::svm_in_t in_item,
  output logic done,
  output svm_pkg::svm_out_t result,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import svm_pkg::*;
  `include "foc_space_vector_modulator_defines.svh"
  localparam int SC_LAT = 3;
  localparam int PRE = SC_LAT;

  logic [14:0] supply;
  logic signed [15:0] vd;
  logic mode;
  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      supply <= 15'd12288;
      vd <= 16'sd0;
      mode <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SUPPLY: supply <= cfg_data[14:0];
        REG_VD: vd <= cfg_data;
        REG_MODE: mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 0: magnitude and half-turn for vector mode
  logic accept;
  logic [15:0] ang0;
  logic signed [16:0] uq0;
  assign accept = start && !busy;
  always_comb begin
    ang0 = in_item.rotor_angle;
    uq0 = 17'(in_item.q_axis_voltage);
    if (!mode && in_item.q_axis_voltage < 0) begin
      ang0 = in_item.rotor_angle + 16'h8000;
      uq0 = -17'(in_item.q_axis_voltage);
    end
  end

  logic signed [17:0] s_val, c_val;
  svm_sincos u_sin (.clk(clk), .phase(ang0), .sin_val(s_val));
  svm_sincos u_cos (.clk(clk), .phase(ang0 + 16'h4000), .sin_val(c_val));

  logic signed [16:0] uq_d [PRE];
  logic vld_d [PRE];
  always_ff @(posedge clk) begin
    uq_d[0] <= uq0;
    for (int i = 1; i < PRE; i++) uq_d[i] <= uq_d[i-1];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PRE; i++) vld_d[i] <= 1'b0;
    end else begin
      vld_d[0] <= accept;
      for (int i = 1; i < PRE; i++) vld_d[i] <= vld_d[i-1];
    end
  end

  // stage a: inverse park
  logic signed [35:0] ua, ub;
  logic va;
  always_ff @(posedge clk) begin
    ua <= 36'(vd * c_val) - 36'(uq_d[PRE-1] * s_val);
    ub <= 36'(vd * s_val) + 36'(uq_d[PRE-1] * c_val);
  end
  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else va <= vld_d[PRE-1];
  end

  // stage b: scaled terms
  logic signed [63:0] ua16, ub3, a3;
  logic vb;
  always_ff @(posedge clk) begin
    ua16 <= 64'(ua) <<< 16;
    ub3 <= 64'(ub) * 64'(SQRT3_Q16);
    a3 <= 64'(ua) * 64'(SQRT3_Q16);
  end
  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else vb <= va;
  end
  logic signed [35:0] ub_b;
  always_ff @(posedge clk) ub_b <= ub;

  // stage c: sector and numerators
  logic [2:0] sec_c;
  logic signed [63:0] n1, n2, pp, b16;
  logic signed [63:0] n1_c, n2_c, n3_c;
  logic [63:0] den;
  logic vc;
  always_comb begin
    logic [2:0] code;
    logic [2:0] sn;
    b16 = 64'(ub_b) <<< 16;
    code = {(-a3 - b16) > 0, (a3 - b16) > 0, ub_b > 0};
    sn = sector_of_code(code);
    pp = 3 * ua16;
    unique case (sn)
      3'd1: begin n1 = pp - ub3; n2 = 2 * ub3; end
      3'd2: begin n1 = pp + ub3; n2 = ub3 - pp; end
      3'd3: begin n1 = 2 * ub3; n2 = -pp - ub3; end
      3'd4: begin n1 = ub3 - pp; n2 = -2 * ub3; end
      3'd5: begin n1 = -pp - ub3; n2 = pp - ub3; end
      default: begin n1 = -2 * ub3; n2 = pp + ub3; end
    endcase
  end
  logic [2:0] sec_n;
  assign sec_n = mode ? 3'd0 : sector_of_code({(-a3 - b16) > 0, (a3 - b16) > 0, ub_b > 0});
  logic [14:0] vs;
  assign vs = (supply == 15'd0) ? 15'd1 : supply;
  assign den = 64'(vs) << 32;
  logic signed [63:0] half;
  assign half = 64'(vs) << 31;

  // numerators of the three lanes for the selected mode
  always_ff @(posedge clk) begin
    if (mode) begin
      n1_c <= 2 * ua16 + half;
      n2_c <= ub3 - ua16 + half;
      n3_c <= -ua16 - ub3 + half;
    end else begin
      n1_c <= n1;
      n2_c <= n2;
      n3_c <= 64'sd0;
    end
    sec_c <= sec_n;
  end
  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else vc <= vb;
  end

  div_lane_t l0 [DIV_STEPS+1];
  div_lane_t l1 [DIV_STEPS+1];
  div_lane_t l2 [DIV_STEPS+1];
  logic [63:0] dvp [DIV_STEPS+1];
  logic modep [DIV_STEPS+1];
  logic [2:0] secp [DIV_STEPS+1];
  logic vp [DIV_STEPS+1];

  function automatic div_lane_t lane_init(input logic signed [63:0] n,
                                          input logic [63:0] d);
    div_lane_t l;
    l.rem = n[63] ? 64'd0 : n;
    l.quo = 18'd0;
    l.sat_lo = (n <= 0);
    l.sat_hi = !n[63] && (64'(n) >= d);
    if (l.sat_lo || l.sat_hi) l.rem = 64'd0;
    return l;
  endfunction

  // stage c2: overmodulation scaling when mode is low, and divider setup
  logic vc2;
  always_ff @(posedge clk) begin
    logic signed [63:0] sum, dvs;
    sum = n1_c + n2_c;
    dvs = (sum > $signed(den)) ? sum : $signed(den);
    if (mode) begin
      dvp[0] <= den;
      l0[0] <= lane_init(n1_c, den);
      l1[0] <= lane_init(n2_c, den);
      l2[0] <= lane_init(n3_c, den);
    end else begin
      dvp[0] <= dvs;
      l0[0] <= lane_init(n1_c, dvs);
      l1[0] <= lane_init(n2_c, dvs);
      l2[0] <= lane_init(n3_c, dvs);
    end
    modep[0] <= mode;
    secp[0] <= sec_c;
  end
  always_ff @(posedge clk) begin
    if (rst) vc2 <= 1'b0;
    else vc2 <= vc;
  end
  assign vp[0] = vc2;

  // divider pipeline, one quotient bit per stage
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    svm_div_lane u_l0 (.clk(clk), .den(dvp[g]), .lane_in(l0[g]), .lane_out(l0[g+1]));
    svm_div_lane u_l1 (.clk(clk), .den(dvp[g]), .lane_in(l1[g]), .lane_out(l1[g+1]));
    svm_div_lane u_l2 (.clk(clk), .den(dvp[g]), .lane_in(l2[g]), .lane_out(l2[g+1]));
    always_ff @(posedge clk) begin
      dvp[g+1] <= dvp[g];
      modep[g+1] <= modep[g];
      secp[g+1] <= secp[g];
    end
    always_ff @(posedge clk) begin
      if (rst) vp[g+1] <= 1'b0;
      else vp[g+1] <= vp[g];
    end
  end

  // rounded ratio at a given fraction width
  function automatic logic [17:0] rat(input div_lane_t l, input logic m);
    logic [17:0] q;
    if (l.sat_lo) return 18'd0;
    if (m) begin
      if (l.sat_hi) return 18'd65536;
      q = (l.quo[16:0] + 18'd1) >> 1;
    end else begin
      if (l.sat_hi) return 18'd32768;
      q = (18'(l.quo[16:1]) + 18'd1) >> 1;
    end
    return q;
  endfunction

  // stage d: duties by sector, or the direct lane ratios when mode is set
  logic [17:0] da, db, dc;
  logic [2:0] sec_d;
  logic vd_s;
  always_ff @(posedge clk) begin
    logic [17:0] t1, t2, h, x1, x2;
    logic signed [18:0] t0;
    logic m;
    m = modep[DIV_STEPS];
    t1 = rat(l0[DIV_STEPS], m);
    t2 = rat(l1[DIV_STEPS], m);
    t0 = 19'sd32768 - 19'(t1) - 19'(t2);
    h = (t0 < 0) ? 18'd0 : t0[17:0];
    x1 = t1 << 1;
    x2 = t2 << 1;
    if (m) begin
      da <= t1; db <= t2; dc <= rat(l2[DIV_STEPS], m);
    end else begin
      unique case (secp[DIV_STEPS])
        3'd1: begin da <= h; db <= h + x1; dc <= h + x1 + x2; end
        3'd2: begin da <= h + x2; db <= h; dc <= h + x1 + x2; end
        3'd3: begin da <= h + x1 + x2; db <= h; dc <= h + x1; end
        3'd4: begin da <= h + x1 + x2; db <= h + x2; dc <= h; end
        3'd5: begin da <= h + x1; db <= h + x1 + x2; dc <= h; end
        default: begin da <= h; db <= h + x1 + x2; dc <= h + x2; end
      endcase
    end
    sec_d <= secp[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (rst) vd_s <= 1'b0;
    else vd_s <= vp[DIV_STEPS];
  end

  // stage e: compare values
  always_ff @(posedge clk) begin
    result.compare_a <= to_compare(da);
    result.compare_b <= to_compare(db);
    result.compare_c <= to_compare(dc);
    result.sector <= sec_d;
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vd_s;
  end

  `SVM_ASSERT(a_sec_range, done |-> result.sector <= 3'd6, "sector out of range")
  `SVM_ASSERT(a_cmp_a, done |-> result.compare_a <= 12'(PWM_PERIOD), "compare a over period")
  `SVM_ASSERT(a_cmp_b, done |-> result.compare_b <= 12'(PWM_PERIOD), "compare b over period")
  `SVM_ASSERT_ALWAYS(a_rst_done, rst |=> !done, "result after reset")
endmodule

>>> verif/testbench.sv
// self-checking testbench for the space vector modulator
module testbench;
  import svm_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int PIPE_DRAIN = 40;
  localparam int N_PHASES = 10;
  localparam int RAND_PER_PHASE = 191;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  svm_in_t in_item = '0;
  logic done;
  svm_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // local copy of the register file
  logic [14:0] supply_reg = 15'd12288;
  logic [15:0] vd_reg = 16'd0;
  logic mode_reg = 1'b0;

  svm_in_t pending_items[$];
  svm_out_t expected_compares[$];
  int send_idle_pct = 0;
  int mismatches = 0;

  foc_space_vector_modulator u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // quarter-wave polynomial sine, q1.15
  function automatic longint sine_q15(input logic [31:0] phase);
    logic [1:0] quad;
    logic [63:0] f, z, z2, t, r;
    quad = phase[31:30];
    f = 64'(phase[29:14]);
    z = quad[0] ? (64'd65536 - f) : f;
    z2 = (z * z) >> 16;
    t = (64'd4640 * z2) >> 16;
    t = 64'd42048 - t;
    t = (t * z2) >> 16;
    t = 64'd102944 - t;
    r = (t * z + 64'd65536) >> 17;
    return quad[1] ? -longint'(r) : longint'(r);
  endfunction

  // rounded n/s in 2^bits units, clamped to 0..2^bits
  function automatic logic [31:0] scaled_ratio(input longint n, input longint s,
                                               input int bits);
    logic [63:0] r, d, q;
    if (n <= 0) return 32'd0;
    if (n >= s) return 32'd1 << bits;
    r = n;
    d = s;
    q = '0;
    for (int i = 0; i <= bits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return 32'((q + 64'd1) >> 1);
  endfunction

  function automatic logic [11:0] duty_to_count(input logic [31:0] duty);
    logic [63:0] c;
    if (duty > 32'd65536) duty = 32'd65536;
    c = (64'(duty) * 64'(PWM_PERIOD) + 64'd32768) >> 16;
    if (c > 64'(PWM_PERIOD)) c = 64'(PWM_PERIOD);
    return c[11:0];
  endfunction

  // expected compare values and sector for one operating point
  function automatic svm_out_t predict_compare(input svm_in_t it);
    longint ka[7] = '{0, 1, 1, 0, -1, -1, 0};
    longint kb[7] = '{0, -1, 1, 2, 1, -1, -2};
    longint kc[7] = '{0, 2, 1, -1, -2, -1, 1};
    longint kd[7] = '{0, 0, -1, -1, 0, 1, 1};
    int code_to_sector[8] = '{1, 2, 6, 1, 4, 3, 5, 1};
    longint uq, ud, vs, den, sn, cs, ua, ub, ua16, ub3, a3, b16, pp, n1, n2, sum, dv;
    longint half;
    logic [15:0] ang;
    logic [31:0] ph, t1, t2, h, x1, x2, da, db, dc;
    int t0, sec;
    logic [2:0] code;
    svm_out_t o;
    uq = longint'(it.q_axis_voltage);
    ud = longint'($signed(vd_reg));
    ang = it.rotor_angle;
    vs = (supply_reg == 0) ? 1 : longint'(supply_reg);
    den = vs * (longint'(1) << 32);
    sec = 0;
    if (!mode_reg && uq < 0) begin
      ang = ang + 16'h8000;
      uq = -uq;
    end
    ph = {ang, 16'h0000};
    sn = sine_q15(ph);
    cs = sine_q15(ph + 32'h4000_0000);
    ua = ud * cs - uq * sn;
    ub = ud * sn + uq * cs;
    ua16 = ua * 65536;
    ub3 = ub * SQRT3_Q16;
    if (!mode_reg) begin
      a3 = ua * SQRT3_Q16;
      b16 = ub * 65536;
      code = {(-a3 - b16) > 0, (a3 - b16) > 0, ub > 0};
      sec = code_to_sector[code];
      pp = 3 * ua16;
      n1 = ka[sec] * pp + kb[sec] * ub3;
      n2 = kd[sec] * pp + kc[sec] * ub3;
      sum = n1 + n2;
      dv = (sum > den) ? sum : den;
      t1 = scaled_ratio(n1, dv, 15);
      t2 = scaled_ratio(n2, dv, 15);
      t0 = 32768 - int'(t1) - int'(t2);
      if (t0 < 0) t0 = 0;
      h = t0;
      x1 = 2 * t1;
      x2 = 2 * t2;
      case (sec)
        1: begin da = h; db = h + x1; dc = h + x1 + x2; end
        2: begin da = h + x2; db = h; dc = h + x1 + x2; end
        3: begin da = h + x1 + x2; db = h; dc = h + x1; end
        4: begin da = h + x1 + x2; db = h + x2; dc = h; end
        5: begin da = h + x1; db = h + x1 + x2; dc = h; end
        default: begin da = h; db = h + x1 + x2; dc = h + x2; end
      endcase
    end else begin
      half = vs * (longint'(1) << 31);
      da = scaled_ratio(2 * ua16 + half, den, 16);
      db = scaled_ratio(ub3 - ua16 + half, den, 16);
      dc = scaled_ratio(-ua16 - ub3 + half, den, 16);
    end
    o.compare_a = duty_to_count(da);
    o.compare_b = duty_to_count(db);
    o.compare_c = duty_to_count(dc);
    o.sector = 3'(sec);
    return o;
  endfunction

  // item driver: predicts on each accepted item
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_compares.push_back(predict_compare(in_item));
      if (!start || !busy) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          start <= 1'b1;
          in_item <= pending_items.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_compares.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        mismatches++;
      end else begin
        svm_out_t e;
        e = expected_compares.pop_front();
        if (result.compare_a !== e.compare_a) begin
          $display("%0t: compare_a expected %0d actual %0d", $time, e.compare_a,
                   result.compare_a);
          mismatches++;
        end
        if (result.compare_b !== e.compare_b) begin
          $display("%0t: compare_b expected %0d actual %0d", $time, e.compare_b,
                   result.compare_b);
          mismatches++;
        end
        if (result.compare_c !== e.compare_c) begin
          $display("%0t: compare_c expected %0d actual %0d", $time, e.compare_c,
                   result.compare_c);
          mismatches++;
        end
        if (result.sector !== e.sector) begin
          $display("%0t: sector expected %0d actual %0d", $time, e.sector,
                   result.sector);
          mismatches++;
        end
      end
    end
  end

  // wait until every item is through the pipeline
  task automatic drain_pipeline();
    wait (pending_items.size() == 0 && !start && expected_compares.size() == 0);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SUPPLY: supply_reg = data[14:0];
      REG_VD: vd_reg = data;
      REG_MODE: mode_reg = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(input int q, input int ang);
    svm_in_t it;
    it.q_axis_voltage = 16'(q);
    it.rotor_angle = 16'(ang);
    pending_items.push_back(it);
  endtask

  // corner operating points: field extremes, sector boundaries, zero vector
  task automatic add_corner_items();
    int qv[6] = '{-32768, 32767, 0, -1, 1, 16384};
    int av[10] = '{0, 65535, 16384, 32768, 49152, 10923, 21845, 43691, 54613, 32767};
    foreach (qv[i]) add_item(qv[i], av[i]);
    foreach (av[i]) add_item((i % 2) ? 8000 : -8000, av[i]);
    add_item(-32768, 0);
    add_item(32767, 65535);
    add_item(0, 43690);
  endtask

  initial begin
    logic [14:0] sup_tab[N_PHASES] = '{15'd12288, 15'd12288, 15'd32767, 15'd1, 15'd0,
                                       15'd32767, 15'd1, 15'd20000, 15'd0, 15'd0};
    logic [15:0] vd_tab[N_PHASES] = '{16'd0, 16'd0, 16'h7fff, 16'h8000, 16'h8000,
                                      16'h8000, 16'h7fff, 16'd5000, 16'd0, 16'd0};
    logic mode_tab[N_PHASES] = '{0, 1, 0, 0, 1, 1, 1, 0, 0, 1};
    int idle_tab[N_PHASES] = '{0, 51, 37, 0, 51, 37, 0, 51, 37, 0};
    logic [14:0] sup;
    logic [15:0] vd;
    int q;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // spare index must be ignored
    write_reg(REG_SPARE, 16'($urandom));
    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_pipeline();
      sup = sup_tab[ph];
      vd = vd_tab[ph];
      if (ph >= 8) begin
        sup = 15'($urandom_range(32767));
        vd = 16'($urandom);
      end
      // top data bit is outside the supply register
      write_reg(REG_SUPPLY, {1'($urandom_range(1)), sup});
      write_reg(REG_VD, vd);
      write_reg(REG_MODE, {15'($urandom), mode_tab[ph]});
      send_idle_pct = idle_tab[ph];
      if (ph < 2) add_corner_items();
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        case ($urandom_range(2))
          0: q = $urandom_range(8191) - 4096;
          1: q = int'(sup) - $urandom_range(2 * int'(sup));
          default: q = $urandom;
        endcase
        add_item(q, $urandom);
      end
    end
    drain_pipeline();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/svm_pkg.sv
rtl/svm_sincos.sv
rtl/svm_div_lane.sv
rtl/foc_space_vector_modulator.sv
verif/testbench.sv
